FILE: sv/spfq_pkg.sv
// Shared types and constants for the strict-priority queue.
// Command and response payloads, status and mode codes, and the per-item verdict.
// No dependencies.
package spfq_pkg;

	localparam int NUM_LEVELS_DEF  = 5;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int TAG_WIDTH_DEF   = 16;

	localparam int LEVEL_W     = 3;
	localparam int TAG_FIELD_W = 16;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_POP    = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEVEL = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                  mode;
		logic [LEVEL_W-1:0]     level;
		logic [TAG_FIELD_W-1:0] item_tag;
	} cmd_t;

	typedef struct packed {
		status_t                status;
		logic [TAG_FIELD_W-1:0] popped_tag;
		logic [LEVEL_W-1:0]     popped_level;
		logic                   all_empty;
	} rsp_t;

	// Outcome of one command, handed from the queue controller to the result stage.
	typedef struct packed {
		status_t            status;
		logic [LEVEL_W-1:0] popped_level;
		logic               all_empty;
		logic               pop_ok;
	} verdict_t;

endpackage

FILE: sv/spfq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module spfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/spfq_ctrl.sv
// Queue controller: per-level head/tail pointers and fill counts, the priority
// encoder over the levels, and the storage address of each command.
// Depends on spfq_pkg.
module spfq_ctrl #(
	parameter int NUM_LEVELS  = spfq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = spfq_pkg::LEVEL_DEPTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        advance,
	input  spfq_pkg::cmd_t                              item,
	output spfq_pkg::verdict_t                          verdict,
	output logic                                        mem_we,
	output logic                                        mem_re,
	output logic [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]   mem_addr
);
	import spfq_pkg::*;

	localparam int LIDX_W = $clog2(NUM_LEVELS);
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);

	logic [PTR_W-1:0]  head_q [NUM_LEVELS];
	logic [PTR_W-1:0]  tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]  cnt_q  [NUM_LEVELS];
	logic [CNT_W-1:0]  cnt_d  [NUM_LEVELS];

	logic              any_q;
	logic              any_d;
	logic [LIDX_W-1:0] top_idx;
	logic              top_found;
	logic [LIDX_W-1:0] ins_idx;
	logic              bad_level;
	logic              ins_full;
	logic              ins_ok;
	logic              pop_ok;
	logic [LIDX_W-1:0] sel_idx;
	logic [PTR_W-1:0]  sel_ptr;

	// Highest non-empty level wins.
	always_comb begin
		top_idx   = '0;
		top_found = 1'b0;
		any_q     = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (cnt_q[i] != '0) begin
				top_idx   = LIDX_W'(i);
				top_found = 1'b1;
				any_q     = 1'b1;
			end
		end
	end

	assign bad_level = (item.level == '0) || (int'(item.level) > NUM_LEVELS);
	assign ins_idx   = LIDX_W'(item.level - LEVEL_W'(1));
	assign ins_full  = !bad_level && (cnt_q[ins_idx] == CNT_W'(LEVEL_DEPTH));
	assign ins_ok    = (item.mode == MODE_INSERT) && !bad_level && !ins_full;
	assign pop_ok    = (item.mode == MODE_POP) && top_found;

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			cnt_d[i] = cnt_q[i];
		end
		if (ins_ok) begin
			cnt_d[ins_idx] = cnt_q[ins_idx] + CNT_W'(1);
		end
		if (pop_ok) begin
			cnt_d[top_idx] = cnt_q[top_idx] - CNT_W'(1);
		end
		any_d = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (cnt_d[i] != '0) begin
				any_d = 1'b1;
			end
		end
	end

	always_comb begin
		verdict.pop_ok       = pop_ok;
		verdict.all_empty    = !any_d;
		verdict.popped_level = pop_ok ? (LEVEL_W'(top_idx) + LEVEL_W'(1)) : '0;
		unique case (item.mode)
			MODE_INSERT: begin
				if (bad_level) begin
					verdict.status = ST_BAD_LEVEL;
				end else if (ins_full) begin
					verdict.status = ST_FULL;
				end else begin
					verdict.status = ST_OK;
				end
			end
			MODE_POP: begin
				verdict.status = top_found ? ST_OK : ST_EMPTY;
			end
			default: begin
				verdict.status = ST_OK;
			end
		endcase
	end

	assign sel_idx  = (item.mode == MODE_POP) ? top_idx : ins_idx;
	assign sel_ptr  = (item.mode == MODE_POP) ? head_q[sel_idx] : tail_q[sel_idx];
	assign mem_addr = ADDR_W'(sel_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(sel_ptr);
	assign mem_we   = advance && ins_ok;
	assign mem_re   = advance && pop_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
			if (ins_ok) begin
				tail_q[ins_idx] <= (tail_q[ins_idx] == PTR_W'(LEVEL_DEPTH - 1)) ?
					'0 : tail_q[ins_idx] + PTR_W'(1);
			end
			if (pop_ok) begin
				head_q[top_idx] <= (head_q[top_idx] == PTR_W'(LEVEL_DEPTH - 1)) ?
					'0 : head_q[top_idx] + PTR_W'(1);
			end
		end
	end

	a_one_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("storage written and read by the same command");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (verdict.status == ST_OK) && any_q)
		else $error("pop issued on an empty queue");

	a_insert_leaves_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> any_q)
		else $error("queue empty right after a stored insert");

	a_empty_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (any_q == !$past(verdict.all_empty)))
		else $error("reported empty flag disagrees with the fill counts");

endmodule

FILE: sv/strict_priority_fifo_queue.sv
// Top level of the strict-priority queue: command register, result register and
// the tag storage. Depends on spfq_pkg, spfq_ctrl and spfq_ram.
//
// Usage:
// Commands arrive on the cmd channel (cmd_valid, cmd_ready, cmd). A command either
// inserts item_tag at the tail of its level (1 is least urgent, NUM_LEVELS most
// urgent) or pops the oldest tag of the highest non-empty level. Each command
// produces exactly one response on the rsp channel (rsp_valid, rsp_ready, rsp) with
// a status code, the popped tag and level (zero unless a pop succeeded), and a flag
// that is set when the queue holds nothing after the command.
// A transfer on cmd is registered first; once the result stage is free the controller
// decides, updates the pointers and fill counts and issues the storage access, and
// the result register captures the verdict while the storage read port registers
// the popped tag. One command is taken per cycle for as long as rsp_ready stays high.
// Each command makes at most one storage access, a write for an insert or a read
// for a pop.
// When the receiver stalls, the response and the storage read data hold, the
// command register fills, and cmd_ready drops until rsp_ready returns.
// Reset empties every level at once; stored tags are left as they are and are
// never read before being written again.
module strict_priority_fifo_queue #(
	parameter int NUM_LEVELS  = spfq_pkg::NUM_LEVELS_DEF,
	parameter int LEVEL_DEPTH = spfq_pkg::LEVEL_DEPTH_DEF,
	parameter int TAG_WIDTH   = spfq_pkg::TAG_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  spfq_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output spfq_pkg::rsp_t rsp
);
	import spfq_pkg::*;

	// Only the low TAG_WIDTH bits of a tag are kept, and never more than the field.
	localparam int STORE_W = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
	localparam int DEPTH   = NUM_LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W  = $clog2(DEPTH);

	cmd_t             cmd_s1;
	logic             valid_s1;
	verdict_t         verdict;
	verdict_t         verdict_s2;
	logic             valid_s2;
	logic             s2_free;
	logic             advance;
	logic             mem_we;
	logic             mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [STORE_W-1:0] rd_tag;

	// The result stage frees up when it is empty or its response is being taken.
	assign s2_free   = !valid_s2 || rsp_ready;
	assign advance   = valid_s1 && s2_free;
	assign cmd_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	spfq_ctrl #(
		.NUM_LEVELS  (NUM_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (cmd_s1),
		.verdict  (verdict),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr)
	);

	// The read data register only loads on a successful pop, so it stays with the
	// response in the result stage through any stall.
	spfq_ram #(
		.WIDTH (STORE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (cmd_s1.item_tag[STORE_W-1:0]),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2 <= verdict;
		end
	end

	assign rsp_valid         = valid_s2;
	assign rsp.status        = verdict_s2.status;
	assign rsp.popped_tag    = verdict_s2.pop_ok ? TAG_FIELD_W'(rd_tag) : '0;
	assign rsp.popped_level  = verdict_s2.popped_level;
	assign rsp.all_empty     = verdict_s2.all_empty;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the strict-priority queue (strict_priority_fifo_queue).
// Predicts every response with a shadow copy of the per-level FIFOs; uses spfq_pkg and the DUT.
module tb;
	import spfq_pkg::*;

	localparam int NUM_LEVELS    = NUM_LEVELS_DEF;
	localparam int LEVEL_DEPTH   = LEVEL_DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 1826;
	localparam int TAIL_CYCLES   = 20;
	// The slowest legal run is far below this, even with every command waiting out the
	// longest receiver hold-off plus the longest sender gap.
	localparam int CYCLE_LIMIT   = 1000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	strict_priority_fifo_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Commands waiting to be offered, and the responses that accepted commands owe us.
	cmd_t cmd_backlog[$];
	rsp_t awaited_rsps[$];
	int   mismatches = 0;

	// Appends one command to the end of the sender's backlog.
	function automatic void add_pending_cmd(cmd_t c);
		cmd_backlog = {cmd_backlog, c};
	endfunction

	// Appends one predicted response to the end of the list the checker works through.
	function automatic void add_awaited_rsp(rsp_t r);
		awaited_rsps = {awaited_rsps, r};
	endfunction

	// Shadow of the queue contents: one ring of tags per level, indexed level - 1.
	logic [TAG_FIELD_W-1:0] shadow_tags [NUM_LEVELS*LEVEL_DEPTH];
	int shadow_head [NUM_LEVELS];
	int shadow_tail [NUM_LEVELS];
	int shadow_fill [NUM_LEVELS];

	// Applies one command to the shadow queue and returns the response it must produce.
	// Inserts go to the tail of their level; a pop scans from the most urgent level down
	// and takes the head of the first level that holds anything.
	function automatic rsp_t serve_command(cmd_t c);
		rsp_t r;
		int   q;
		int   lv;
		bit   found;
		r = '0;
		r.status = ST_OK;
		if (c.mode == MODE_INSERT) begin
			if (c.level < 1 || c.level > NUM_LEVELS) begin
				r.status = ST_BAD_LEVEL;
			end else begin
				q = int'(c.level) - 1;
				if (shadow_fill[q] >= LEVEL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_tags[q*LEVEL_DEPTH + shadow_tail[q]] = c.item_tag;
					shadow_tail[q] = (shadow_tail[q] + 1) % LEVEL_DEPTH;
					shadow_fill[q]++;
				end
			end
		end else begin
			// Level and tag of a pop carry no meaning and are ignored.
			found = 1'b0;
			for (lv = NUM_LEVELS; lv >= 1 && !found; lv--) begin
				q = lv - 1;
				if (shadow_fill[q] != 0) begin
					r.popped_tag   = shadow_tags[q*LEVEL_DEPTH + shadow_head[q]];
					r.popped_level = LEVEL_W'(lv);
					shadow_head[q] = (shadow_head[q] + 1) % LEVEL_DEPTH;
					shadow_fill[q]--;
					found = 1'b1;
				end
			end
			if (!found)
				r.status = ST_EMPTY;
		end
		r.all_empty = 1'b1;
		for (q = 0; q < NUM_LEVELS; q++)
			if (shadow_fill[q] != 0)
				r.all_empty = 1'b0;
		return r;
	endfunction

	function automatic cmd_t make_cmd(mode_t m, int lv, int tag);
		cmd_t c;
		c.mode     = m;
		c.level    = LEVEL_W'(lv);
		c.item_tag = TAG_FIELD_W'(tag);
		return c;
	endfunction

	// Sender. It offers commands in bursts of random length separated by random gaps;
	// a quarter of the bursts follow the previous one with no gap at all. Each accepted
	// transfer is run through the shadow queue at the edge that accepts it, so the
	// expected responses line up in the order the block sees the commands.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready)
				add_awaited_rsp(serve_command(cmd));
			// Only touch the channel when the current command has gone or none is shown.
			if (!cmd_valid || cmd_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					cmd       <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker. Responses are compared at the edge that accepts them.
	// The ready pattern steps through phases in turn: always ready, mostly ready, mostly
	// stalled, then a fixed one-in-five stall. On top of that come rare long hold-offs,
	// and one forced hold-off early in the run long enough to fill the block and
	// stall the command side while the sender keeps offering.
	int   rx_cycle  = 0;
	int   hold_left = 0;
	rsp_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsps.size() == 0) begin
					$error("response with nothing outstanding: %p", rsp);
					mismatches++;
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.popped_tag !== want.popped_tag) begin
						$error("popped_tag: expected %h, got %h",
							want.popped_tag, rsp.popped_tag);
						mismatches++;
					end
					if (rsp.popped_level !== want.popped_level) begin
						$error("popped_level: expected %0d, got %0d",
							want.popped_level, rsp.popped_level);
						mismatches++;
					end
					if (rsp.all_empty !== want.all_empty) begin
						$error("all_empty: expected %b, got %b",
							want.all_empty, rsp.all_empty);
						mismatches++;
					end
				end
			end

			rx_cycle++;
			if (rx_cycle == 700)
				hold_left = 120;
			else if (hold_left == 0 && $urandom_range(0, 399) == 0)
				hold_left = $urandom_range(40, 90);

			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				case ((rx_cycle / 256) % 4)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 3) != 0);
					2: rsp_ready <= ($urandom_range(0, 9) < 4);
					default: rsp_ready <= ((rx_cycle % 5) != 0);
				endcase
			end
		end
	end

	// Watchdog.
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int i;
		int lv;
		int insert_pct;
		int run_len;
		int random_count;

		// Directed part: pop on an empty queue, out-of-range levels on both sides,
		// extreme tags at the lowest and highest level, priority order on pop,
		// then one level filled to the brim and overflowed.
		add_pending_cmd(make_cmd(MODE_POP, 0, 0));
		add_pending_cmd(make_cmd(MODE_INSERT, 0, 'h1234));
		add_pending_cmd(make_cmd(MODE_INSERT, 7, 'hFFFF));
		add_pending_cmd(make_cmd(MODE_INSERT, 1, 'h0000));
		add_pending_cmd(make_cmd(MODE_INSERT, 5, 'hFFFF));
		add_pending_cmd(make_cmd(MODE_POP, 7, 'hFFFF));
		add_pending_cmd(make_cmd(MODE_POP, 6, 'hA5A5));
		for (i = 0; i <= LEVEL_DEPTH; i++)
			add_pending_cmd(make_cmd(MODE_INSERT, 4, $urandom_range(0, 65535)));

		// Random part: runs with an insert-heavy, balanced or pop-heavy mix, so the
		// levels repeatedly fill to overflow and drain to empty. A few inserts use a
		// level outside the legal range; pops carry random don't-care fields.
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 50;
				default: insert_pct = 20;
			endcase
			run_len = $urandom_range(40, 160);
			for (i = 0; i < run_len && random_count < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < insert_pct) begin
					if ($urandom_range(0, 99) < 7)
						lv = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(6, 7);
					else
						lv = $urandom_range(1, NUM_LEVELS);
					add_pending_cmd(make_cmd(MODE_INSERT, lv,
						$urandom_range(0, 65535)));
				end else begin
					add_pending_cmd(make_cmd(MODE_POP, $urandom_range(0, 7),
						$urandom_range(0, 65535)));
				end
				random_count++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every command offered and accepted, every response seen, then a
		// short tail to catch any stray response.
		while (cmd_backlog.size() != 0 || cmd_valid)
			@(posedge clk);
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
